### hw/rtl/peaking_eq_coefficient_calc_assert.svh
// assertion helpers shared by the coefficient calculator
`ifndef PEAKING_EQ_COEFFICIENT_CALC_ASSERT_SVH
`define PEAKING_EQ_COEFFICIENT_CALC_ASSERT_SVH

// same-cycle implication
`define PEC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/pec_pkg.sv
package pec_pkg;

   // register indexes of the configuration port
   localparam logic CSR_Q_FACTOR    = 1'b0;
   localparam logic CSR_SAMPLE_RATE = 1'b1;

   localparam logic [11:0] Q_RESET  = 12'd256;
   localparam logic [17:0] FS_RESET = 18'd44100;
   localparam logic [11:0] Q_MIN    = 12'd26;
   localparam logic [11:0] Q_MAX    = 12'd2560;
   localparam logic [17:0] FS_MIN   = 18'd8000;
   localparam logic [17:0] FS_MAX   = 18'd192000;
   localparam logic signed [12:0] GAIN_MAX = 13'sd3072;
   localparam logic signed [12:0] GAIN_MIN = -13'sd3072;

   // fixed-point constants, Q30
   localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
   localparam logic [17:0] LN10_STEP = 18'd241443;
   localparam logic [33:0] TWOPI_Q30 = 34'd6746518852;

   localparam int EXP_TERMS  = 16;
   localparam int TRIG_TERMS = 20;

   // quotient widths of the dividers and the numerator magnitude width
   localparam int PH_QW = 31;
   localparam int AL_QW = 34;
   localparam int AD_QW = 36;
   localparam int MAG_W = 37;

   localparam int REQ_W = 40;
   localparam int RSP_W = 168;

   // data handed from one series cell to the next
   typedef struct packed {
      logic               valid;
      logic signed [31:0] value;
      logic signed [31:0] factor;
      logic signed [33:0] acc0;
      logic signed [33:0] acc1;
   } ser_type;

endpackage

### hw/rtl/peaking_eq_coefficient_calc.sv
// Peaking equaliser coefficient calculator. Each request carries a band tag, a gain in
// 1/256 dB and a centre frequency in Hz; the response carries b0/a0, b1/a0, b2/a0, a1/a0
// and a2/a0 as signed fixed point with COEFF_FRAC_BITS fraction bits, saturating, plus the
// tag. Q (1/256 units) and the sample rate come from the csr port and are sampled when a
// request leaves the input register, so write them only while no request is in flight.
// Gain, Q and sample rate are clamped to their legal ranges and a frequency at or above
// Nyquist is pulled just below it. The pipeline takes one request per clock while no
// response is stalled. Requests pass through the chain of series cells, each registering
// the product, the scaled quotient and then the signed term, and through the restoring
// dividers, one quotient bit per cell. A stalled response stalls the whole pipeline,
// while the input register can still take one more request.
`include "peaking_eq_coefficient_calc_assert.svh"

module peaking_eq_coefficient_calc #(
   parameter int COEFF_FRAC_BITS = 28
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // band_index[2:0], gain_db[15:3], frequency_hz[32:16], zero fill
   input  logic [pec_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // band_tag[2:0], feed_zero[34:3], feed_one[66:35], feed_two[98:67],
   // back_one[130:99], back_two[162:131], zero fill
   output logic [pec_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [0:0]                csr_index,
   input  logic [17:0]               csr_wdata
);

   localparam int RAT_QW = COEFF_FRAC_BITS + 7;
   localparam int RAT_NW = pec_pkg::MAG_W + COEFF_FRAC_BITS;

   logic adv;
   logic in_valid_ff;

   // configuration registers
   logic [11:0] q_factor_ff;
   logic [17:0] sample_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_factor_ff    <= pec_pkg::Q_RESET;
         sample_rate_ff <= pec_pkg::FS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pec_pkg::CSR_Q_FACTOR:    q_factor_ff    <= csr_wdata[11:0];
            pec_pkg::CSR_SAMPLE_RATE: sample_rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless a response is waiting
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv || !in_valid_ff;

   // input register
   logic [2:0]  band_ff;
   logic [12:0] gain_ff;
   logic [16:0] freq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         band_ff <= req_tdata[2:0];
         gain_ff <= req_tdata[15:3];
         freq_ff <= req_tdata[32:16];
      end
   end

   // clamping and exponent argument
   logic signed [12:0] gain_s, gain_c;
   logic signed [31:0] x_in, x_ff;
   logic [17:0]        fs_c, fs_m1, fs_ff;
   logic [11:0]        q_c, q_ff;
   logic [16:0]        f_in, f_ff;
   logic [2:0]         b_band_ff;
   logic               b_valid_ff;

   assign gain_s = $signed(gain_ff);
   assign gain_c = (gain_s > pec_pkg::GAIN_MAX) ? pec_pkg::GAIN_MAX :
                   (gain_s < pec_pkg::GAIN_MIN) ? pec_pkg::GAIN_MIN : gain_s;
   assign x_in   = 32'(gain_c) * $signed({1'b0, pec_pkg::LN10_STEP});
   assign fs_c   = (sample_rate_ff < pec_pkg::FS_MIN) ? pec_pkg::FS_MIN :
                   (sample_rate_ff > pec_pkg::FS_MAX) ? pec_pkg::FS_MAX : sample_rate_ff;
   assign q_c    = (q_factor_ff < pec_pkg::Q_MIN) ? pec_pkg::Q_MIN :
                   (q_factor_ff > pec_pkg::Q_MAX) ? pec_pkg::Q_MAX : q_factor_ff;
   assign fs_m1  = fs_c - 18'd1;
   assign f_in   = ({freq_ff, 1'b0} >= fs_c) ? fs_m1[17:1] : freq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff      <= x_in;
         fs_ff     <= fs_c;
         q_ff      <= q_c;
         f_ff      <= f_in;
         b_band_ff <= band_ff;
      end
   end

   // exponential series, A = exp(x)
   localparam int EXP_PW = 3 + 17 + 18 + 12;
   pec_pkg::ser_type     exp_ser [pec_pkg::EXP_TERMS+1];
   logic [EXP_PW-1:0]    exp_pay [pec_pkg::EXP_TERMS+1];

   always_comb begin
      exp_ser[0].valid  = b_valid_ff;
      exp_ser[0].value  = $signed(pec_pkg::Q30_ONE);
      exp_ser[0].factor = x_ff;
      exp_ser[0].acc0   = 34'($signed(pec_pkg::Q30_ONE));
      exp_ser[0].acc1   = '0;
   end
   assign exp_pay[0] = {b_band_ff, f_ff, fs_ff, q_ff};

   for (genvar k = 0; k < pec_pkg::EXP_TERMS; k++) begin : g_exp
      pec_series_cell #(.N(k + 1), .ACC_SEL(1'b0), .ACC_NEG(1'b0), .PW(EXP_PW)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ser_in (exp_ser[k]),
         .pay_in (exp_pay[k]),
         .ser_out(exp_ser[k+1]),
         .pay_out(exp_pay[k+1])
      );
   end

   // phase in turns, f * 2^32 / fs
   logic signed [33:0] amp;
   logic [31:0]        ua;
   logic [2:0]         e_band;
   logic [16:0]        e_f;
   logic [17:0]        e_fs;
   logic [11:0]        e_q;

   assign amp = exp_ser[pec_pkg::EXP_TERMS].acc0;
   assign ua  = (amp <= 34'sd0) ? pec_pkg::Q30_ONE : amp[31:0];
   assign {e_band, e_f, e_fs, e_q} = exp_pay[pec_pkg::EXP_TERMS];

   localparam int PH_PW = 3 + 12 + 32;
   logic                    ph_valid;
   logic [pec_pkg::PH_QW-1:0] ph;
   logic [PH_PW-1:0]        ph_pay;

   pec_div_chain #(.NW(49), .DW(18), .QW(pec_pkg::PH_QW), .PW(PH_PW)) u_phase_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (exp_ser[pec_pkg::EXP_TERMS].valid),
      .num      ({e_f, 32'd0}),
      .den      (e_fs),
      .pay_in   ({e_band, e_q, ua}),
      .out_valid(ph_valid),
      .quo      (ph),
      .pay_out  (ph_pay)
   );

   // quarter-wave fold and omega partial products
   logic        flip_in, c_flip_ff, c_valid_ff;
   logic [31:0] ph_fold;
   logic [47:0] c_lo_in, c_hi_in, c_lo_ff, c_hi_ff;
   logic [PH_PW-1:0] c_pay_ff;

   assign flip_in = ph > 31'h4000_0000;
   assign ph_fold = flip_in ? 32'h8000_0000 - 32'(ph) : 32'(ph);
   assign c_lo_in = 48'(ph_fold[30:0]) * 48'(pec_pkg::TWOPI_Q30[16:0]);
   assign c_hi_in = 48'(ph_fold[30:0]) * 48'(pec_pkg::TWOPI_Q30[33:17]);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= ph_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_lo_ff   <= c_lo_in;
         c_hi_ff   <= c_hi_in;
         c_flip_ff <= flip_in;
         c_pay_ff  <= ph_pay;
      end
   end

   // omega in Q30 radians
   logic [64:0] w_sum;
   logic [31:0] w_ff;
   logic        d_valid_ff, d_flip_ff;
   logic [PH_PW-1:0] d_pay_ff;

   assign w_sum = {c_hi_ff, 17'd0} + 65'(c_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff      <= w_sum[63:32];
         d_flip_ff <= c_flip_ff;
         d_pay_ff  <= c_pay_ff;
      end
   end

   // sine and cosine series, acc0 = sin, acc1 = cos
   localparam int TRIG_PW = PH_PW + 1;
   pec_pkg::ser_type   trig_ser [pec_pkg::TRIG_TERMS+1];
   logic [TRIG_PW-1:0] trig_pay [pec_pkg::TRIG_TERMS+1];

   always_comb begin
      trig_ser[0].valid  = d_valid_ff;
      trig_ser[0].value  = $signed(pec_pkg::Q30_ONE);
      trig_ser[0].factor = $signed(w_ff);
      trig_ser[0].acc0   = '0;
      trig_ser[0].acc1   = 34'($signed(pec_pkg::Q30_ONE));
   end
   assign trig_pay[0] = {d_pay_ff, d_flip_ff};

   for (genvar k = 0; k < pec_pkg::TRIG_TERMS; k++) begin : g_trig
      pec_series_cell #(
         .N      (k + 1),
         .ACC_SEL(((k + 1) % 2) == 0),
         .ACC_NEG((((k + 1) % 4) == 2) || (((k + 1) % 4) == 3)),
         .PW     (TRIG_PW)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ser_in (trig_ser[k]),
         .pay_in (trig_pay[k]),
         .ser_out(trig_ser[k+1]),
         .pay_out(trig_pay[k+1])
      );
   end

   // alpha = sin * 128 / q
   logic signed [33:0] sn, sn_c, cs_raw, cs;
   logic [2:0]         t_band;
   logic [11:0]        t_q;
   logic [31:0]        t_ua;
   logic               t_flip;

   assign sn     = trig_ser[pec_pkg::TRIG_TERMS].acc0;
   assign cs_raw = trig_ser[pec_pkg::TRIG_TERMS].acc1;
   assign {t_band, t_q, t_ua, t_flip} = trig_pay[pec_pkg::TRIG_TERMS];
   assign sn_c   = (sn < 34'sd0) ? 34'sd0 : sn;
   assign cs     = t_flip ? -cs_raw : cs_raw;

   localparam int AL_PW = 3 + 32 + 34;
   logic                      al_valid;
   logic [pec_pkg::AL_QW-1:0] alpha;
   logic [AL_PW-1:0]          al_pay;

   pec_div_chain #(.NW(38), .DW(12), .QW(pec_pkg::AL_QW), .PW(AL_PW)) u_alpha_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (trig_ser[pec_pkg::TRIG_TERMS].valid),
      .num      ({sn_c[30:0], 7'd0}),
      .den      (t_q),
      .pay_in   ({t_band, t_ua, cs}),
      .out_valid(al_valid),
      .quo      (alpha),
      .pay_out  (al_pay)
   );

   // alpha * A, two partial products then sum
   logic [49:0] e_lo_in, e_hi_in, e_lo_ff, e_hi_ff;
   logic [pec_pkg::AL_QW-1:0] e_alpha_ff, f_alpha_ff;
   logic [AL_PW-1:0] e_pay_ff;
   logic        e_valid_ff, f_valid_ff;
   logic [31:0] a_ua;
   logic [31:0] a_ua_unused;
   logic [65:0] amul_sum;
   logic [35:0] f_amul_ff;
   logic [31:0] f_ua_ff;
   logic [2:0]  f_band_ff, a_band;
   logic signed [33:0] f_cs_ff, a_cs;

   assign a_ua    = al_pay[65:34];
   assign e_lo_in = 50'(alpha) * 50'(a_ua[15:0]);
   assign e_hi_in = 50'(alpha) * 50'(a_ua[31:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= al_valid;
         f_valid_ff <= e_valid_ff;
      end
   end

   assign {a_band, a_ua_unused, a_cs} = e_pay_ff;
   assign amul_sum = {e_hi_ff, 16'd0} + 66'(e_lo_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         e_lo_ff    <= e_lo_in;
         e_hi_ff    <= e_hi_in;
         e_alpha_ff <= alpha;
         e_pay_ff   <= al_pay;
         f_amul_ff  <= amul_sum[65:30];
         f_alpha_ff <= e_alpha_ff;
         f_ua_ff    <= a_ua_unused;
         f_band_ff  <= a_band;
         f_cs_ff    <= a_cs;
      end
   end

   // alpha / A
   localparam int AD_PW = 3 + 36 + 34;
   logic                      ad_valid;
   logic [pec_pkg::AD_QW-1:0] adiv;
   logic [AD_PW-1:0]          ad_pay;

   pec_div_chain #(.NW(64), .DW(32), .QW(pec_pkg::AD_QW), .PW(AD_PW)) u_adiv_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (f_valid_ff),
      .num      ({f_alpha_ff, 30'd0}),
      .den      (f_ua_ff),
      .pay_in   ({f_band_ff, f_amul_ff, f_cs_ff}),
      .out_valid(ad_valid),
      .quo      (adiv),
      .pay_out  (ad_pay)
   );

   // numerators as sign and magnitude, and the common denominator
   function automatic logic [37:0] abs38(logic [37:0] d);
      return d[37] ? 38'd0 - d : d;
   endfunction

   logic [2:0]         n_band;
   logic [35:0]        n_amul;
   logic signed [33:0] n_cs;
   logic [37:0]        d_b0, d_b1, d_b2, d_a2, m_b0, m_b1, m_b2, m_a2;
   logic [3:0]         g_neg_in, g_neg_ff;
   logic [pec_pkg::MAG_W-1:0] g_mag_ff [4];
   logic [pec_pkg::MAG_W-1:0] g_a0_ff;
   logic [2:0]         g_band_ff;
   logic               g_valid_ff;

   assign {n_band, n_amul, n_cs} = ad_pay;
   assign d_b0 = 38'(pec_pkg::Q30_ONE) + 38'(n_amul);
   assign d_b1 = 38'sd0 - (38'(n_cs) <<< 1);
   assign d_b2 = 38'(pec_pkg::Q30_ONE) - 38'(n_amul);
   assign d_a2 = 38'(pec_pkg::Q30_ONE) - 38'(adiv);
   assign m_b0 = abs38(d_b0);
   assign m_b1 = abs38(d_b1);
   assign m_b2 = abs38(d_b2);
   assign m_a2 = abs38(d_a2);
   assign g_neg_in = {d_a2[37], d_b2[37], d_b1[37], d_b0[37]};

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= ad_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_neg_ff    <= g_neg_in;
         g_mag_ff[0] <= m_b0[pec_pkg::MAG_W-1:0];
         g_mag_ff[1] <= m_b1[pec_pkg::MAG_W-1:0];
         g_mag_ff[2] <= m_b2[pec_pkg::MAG_W-1:0];
         g_mag_ff[3] <= m_a2[pec_pkg::MAG_W-1:0];
         g_a0_ff     <= pec_pkg::MAG_W'(pec_pkg::Q30_ONE) + pec_pkg::MAG_W'(adiv);
         g_band_ff   <= n_band;
      end
   end

   // ratio lanes: b0, b1, b2, a2 over a0, then saturation
   logic [3:0]        r_valid;
   logic [RAT_QW-1:0] r_quo [4];
   logic [3:0]        r_neg [4];
   logic [2:0]        r_band [4];
   logic [31:0]       r_out [4];

   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [63:0] rx, rsat, rneg;

      pec_div_chain #(.NW(RAT_NW), .DW(pec_pkg::MAG_W), .QW(RAT_QW), .PW(7)) u_ratio_div (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_valid (g_valid_ff),
         .num      ({g_mag_ff[k], {COEFF_FRAC_BITS{1'b0}}}),
         .den      (g_a0_ff),
         .pay_in   ({g_band_ff, g_neg_ff}),
         .out_valid(r_valid[k]),
         .quo      (r_quo[k]),
         .pay_out  ({r_band[k], r_neg[k]})
      );

      assign rx   = 64'(r_quo[k]);
      assign rsat = (rx > 64'h8000_0000) ? 64'h8000_0000 : rx;
      assign rneg = 64'd0 - rsat;
      assign r_out[k] = r_neg[k][k] ? rneg[31:0] :
                        (rx > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rx[31:0];
   end

   // response register
   logic                      rsp_valid_ff;
   logic [pec_pkg::RSP_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= r_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {5'd0, r_out[3], r_out[1], r_out[2], r_out[1], r_out[0], r_band[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks on pipeline control and result assembly
   `PEC_ASSERT_IMPLY(a_ready_only_when_full, clock, reset, !req_tready, in_valid_ff,
                     "input register refused a transfer while empty")
   `PEC_ASSERT_NEXT(a_input_loaded, clock, reset, req_tvalid && req_tready, in_valid_ff,
                    "accepted request not held in input register")
   `PEC_ASSERT_IMPLY(a_back_one_matches, clock, reset, rsp_tvalid,
                     rsp_tdata[130:99] == rsp_tdata[66:35],
                     "a1 ratio differs from b1 ratio")
   `PEC_ASSERT_IMPLY(a_lanes_aligned, clock, reset, r_valid[0],
                     r_valid[1] && r_valid[2] && r_valid[3],
                     "ratio lanes out of step")

endmodule

### hw/rtl/pec_series_cell.sv
module pec_series_cell #(
   parameter int N       = 1,
   parameter bit ACC_SEL = 1'b0,
   parameter bit ACC_NEG = 1'b0,
   parameter int PW      = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  pec_pkg::ser_type  ser_in,
   input  logic [PW-1:0]     pay_in,
   output pec_pkg::ser_type  ser_out,
   output logic [PW-1:0]     pay_out
);

   // reciprocal of the term index, floor(2^33 / n)
   localparam logic [33:0] RECIP = 34'((64'd1 << 33) / N);
   localparam logic [5:0]  N_L   = 6'(N);

   pec_pkg::ser_type   s1_ff, s2_ff, s3_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic [PW-1:0]      pay1_ff, pay2_ff, pay3_ff;
   logic               neg_ff, neg_in;
   logic [31:0]        u_ff, u_in;
   logic [65:0]        qm_ff, qm_in;
   logic [63:0]        mag;
   logic [31:0]        q_est, q_fix;
   logic [37:0]        qn, rem;
   logic signed [31:0] term_mag, term;
   logic signed [33:0] term_ext;
   pec_pkg::ser_type   s3_in;

   // stage one: term times factor
   assign prod_in = ser_in.value * ser_in.factor;

   // stage two: magnitude over 2^30, times reciprocal
   assign mag    = prod_ff[63] ? 64'd0 - prod_ff : prod_ff;
   assign neg_in = prod_ff[63];
   assign u_in   = mag[61:30];
   assign qm_in  = 66'(u_in) * 66'(RECIP);

   // stage three: one correction step, sign and accumulate
   assign q_est    = qm_ff[64:33];
   assign qn       = 38'(q_est) * 38'(N_L);
   assign rem      = 38'(u_ff) - qn;
   assign q_fix    = (rem >= 38'(N_L)) ? q_est + 32'd1 : q_est;
   assign term_mag = {1'b0, q_fix[30:0]};
   assign term     = neg_ff ? -term_mag : term_mag;
   assign term_ext = 34'(term);

   always_comb begin
      s3_in       = s2_ff;
      s3_in.value = term;
      if (ACC_SEL == 1'b0) begin
         s3_in.acc0 = ACC_NEG ? s2_ff.acc0 - term_ext : s2_ff.acc0 + term_ext;
      end else begin
         s3_in.acc1 = ACC_NEG ? s2_ff.acc1 - term_ext : s2_ff.acc1 + term_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ff <= ser_in;
         s2_ff <= s1_ff;
         s3_ff <= s3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         pay1_ff <= pay_in;
         neg_ff  <= neg_in;
         u_ff    <= u_in;
         qm_ff   <= qm_in;
         pay2_ff <= pay1_ff;
         pay3_ff <= pay2_ff;
      end
   end

   assign ser_out = s3_ff;
   assign pay_out = pay3_ff;

endmodule

### hw/rtl/pec_div_chain.sv
module pec_div_chain #(
   parameter int NW = 48,
   parameter int DW = 16,
   parameter int QW = 32,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [PW-1:0] pay_in,
   output logic          out_valid,
   output logic [QW-1:0] quo,
   output logic [PW-1:0] pay_out
);

   // one restoring step per cell, quotient bit from the top down
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [PW-1:0] pay_ff [QW];
   logic [QW-1:0] vld_ff;
   logic [NW-QW+DW-1:0] hi_ext;

   // upper numerator bits are known to lie below the divisor
   assign hi_ext = {{DW{1'b0}}, num[NW-1:QW]};

   for (genvar k = 0; k < QW; k++) begin : g_cell
      logic [DW-1:0] stg_rem;
      logic [QW-1:0] stg_low, stg_quo;
      logic [DW-1:0] stg_den;
      logic [PW-1:0] stg_pay;
      logic          stg_vld;
      logic [DW:0]   trial, diff;
      logic          take;

      if (k == 0) begin : g_head
         assign stg_rem = hi_ext[DW-1:0];
         assign stg_low = num[QW-1:0];
         assign stg_quo = '0;
         assign stg_den = den;
         assign stg_pay = pay_in;
         assign stg_vld = in_valid;
      end else begin : g_link
         assign stg_rem = rem_ff[k-1];
         assign stg_low = low_ff[k-1];
         assign stg_quo = quo_ff[k-1];
         assign stg_den = den_ff[k-1];
         assign stg_pay = pay_ff[k-1];
         assign stg_vld = vld_ff[k-1];
      end

      assign trial = {stg_rem, stg_low[QW-1]};
      assign diff  = trial - {1'b0, stg_den};
      assign take  = trial >= {1'b0, stg_den};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= stg_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
            low_ff[k] <= {stg_low[QW-2:0], 1'b0};
            quo_ff[k] <= {stg_quo[QW-2:0], take};
            den_ff[k] <= stg_den;
            pay_ff[k] <= stg_pay;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign quo       = quo_ff[QW-1];
   assign pay_out   = pay_ff[QW-1];

endmodule

### tb/sv/peaking_eq_coefficient_calc_tb.sv
`timescale 1ns / 1ps

module peaking_eq_coefficient_calc_tb;

   localparam int FRAC = 28;
   localparam int LATENCY = 224 + FRAC;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic [2:0]  tag;
      logic [31:0] feed_zero;
      logic [31:0] feed_one;
      logic [31:0] feed_two;
      logic [31:0] back_one;
      logic [31:0] back_two;
   } coeff_set_type;

   // expected coefficient sets, with its own copy of q and sample rate
   class coeff_scoreboard;
      coeff_set_type expected_q[$];
      logic [11:0] q_reg = pec_pkg::Q_RESET;
      logic [17:0] fs_reg = pec_pkg::FS_RESET;
      int          errors = 0;

      // quotient in signed fixed point, magnitude truncated, saturating
      function automatic logic [31:0] ratio_q(longint num, longint den);
         longint unsigned mag, d, whole, rem, r;
         bit neg;
         neg = num < 0;
         mag = neg ? longint'(-num) : num;
         d = den;
         whole = mag / d;
         rem = mag % d;
         if (whole > 64'hFFFF_FFFF) r = 64'hFF_FFFF_FFFF;
         else r = (whole << FRAC) + (rem << FRAC) / d;
         if (neg) begin
            if (r > 64'h8000_0000) r = 64'h8000_0000;
            return 32'(0 - r);
         end
         if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
         return r[31:0];
      endfunction

      function automatic coeff_set_type peaking_coeffs(logic [2:0] band,
                                                       logic signed [12:0] gain,
                                                       logic [16:0] freq);
         longint g, x, term, amp, sn, cs, one, step, b0, b1, b2, a0, a2;
         longint unsigned f, fs, q, ph, w, p, alpha, ua, amul, adiv, twopi;
         bit flip;
         coeff_set_type res;
         one = longint'(pec_pkg::Q30_ONE);
         step = longint'(pec_pkg::LN10_STEP);
         twopi = pec_pkg::TWOPI_Q30;
         flip = 0;
         g = gain;
         if (g > 3072) g = 3072;
         if (g < -3072) g = -3072;
         fs = fs_reg < pec_pkg::FS_MIN ? pec_pkg::FS_MIN :
              (fs_reg > pec_pkg::FS_MAX ? pec_pkg::FS_MAX : fs_reg);
         q = q_reg < pec_pkg::Q_MIN ? pec_pkg::Q_MIN :
             (q_reg > pec_pkg::Q_MAX ? pec_pkg::Q_MAX : q_reg);
         // amplitude from the exponential series
         x = g * step;
         term = one;
         amp = one;
         for (int n = 1; n <= 16; n++) begin
            term = term * x / (longint'(n) * one);
            amp += term;
         end
         if (amp <= 0) amp = one;
         ua = amp;
         // phase, folded into the first quarter turn
         f = freq;
         if (2 * f >= fs) f = (fs - 1) / 2;
         ph = (f << 32) / fs;
         if (ph > (64'd1 << 30)) begin
            ph = (64'd1 << 31) - ph;
            flip = 1;
         end
         w = (ph * twopi) >> 32;
         // sine and cosine series
         sn = 0;
         cs = one;
         p = one;
         for (int n = 1; n <= 20; n++) begin
            p = p * w / (longint'(n) << 30);
            case (n & 3)
               1: sn += longint'(p);
               2: cs -= longint'(p);
               3: sn -= longint'(p);
               default: cs += longint'(p);
            endcase
         end
         if (sn < 0) sn = 0;
         if (flip) cs = -cs;
         alpha = (longint'(sn) * 128) / q;
         amul = (alpha * ua) >> 30;
         adiv = (alpha << 30) / ua;
         b0 = one + longint'(amul);
         b1 = -2 * cs;
         b2 = one - longint'(amul);
         a0 = one + longint'(adiv);
         a2 = one - longint'(adiv);
         res.tag = band;
         res.feed_zero = ratio_q(b0, a0);
         res.feed_one = ratio_q(b1, a0);
         res.feed_two = ratio_q(b2, a0);
         res.back_one = ratio_q(b1, a0);
         res.back_two = ratio_q(a2, a0);
         return res;
      endfunction

      function void note_request(logic [pec_pkg::REQ_W-1:0] data);
         expected_q.push_back(peaking_coeffs(data[2:0], data[15:3], data[32:16]));
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_response(logic [pec_pkg::RSP_W-1:0] data);
         coeff_set_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, data);
            return;
         end
         e = expected_q.pop_front();
         compare_field("band_tag", 32'(e.tag), 32'(data[2:0]));
         compare_field("feed_zero", e.feed_zero, data[34:3]);
         compare_field("feed_one", e.feed_one, data[66:35]);
         compare_field("feed_two", e.feed_two, data[98:67]);
         compare_field("back_one", e.back_one, data[130:99]);
         compare_field("back_two", e.back_two, data[162:131]);
      endfunction
   endclass

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      req_tvalid = 0;
   logic                      req_tready;
   logic [pec_pkg::REQ_W-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 0;
   logic [pec_pkg::RSP_W-1:0] rsp_tdata;
   logic                      csr_we = 0;
   logic [0:0]                csr_index = '0;
   logic [17:0]               csr_wdata = '0;

   coeff_scoreboard sb = new();
   bit              no_idle = 0;
   int              quiet_cycles = 0;

   peaking_eq_coefficient_calc #(.COEFF_FRAC_BITS(FRAC)) dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // transfer monitor, receiver stalls and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
         rsp_tready <= no_idle || ($urandom_range(99) >= 11);
      end
   end

   // one idle cycle before roughly one band in eight
   task automatic send_band(logic [2:0] band, logic [12:0] gain, logic [16:0] freq);
      if (!no_idle && $urandom_range(99) < 12) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'd0, freq, gain, band};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random_band();
      logic [12:0] gain;
      logic [16:0] freq;
      int sel;
      sel = $urandom_range(99);
      gain = sel < 80 ? 13'($urandom_range(6144) - 3072) : 13'($urandom);
      sel = $urandom_range(99);
      if (sel < 50) freq = 17'($urandom_range(1, 24000));
      else if (sel < 75) freq = 17'($urandom_range(1, 96000));
      else freq = 17'($urandom);
      send_band(3'($urandom), gain, freq);
   endtask

   // let every expected response arrive, then some settling time
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   task automatic write_settings(logic [11:0] q, logic [17:0] fs);
      csr_we <= 1;
      csr_index <= pec_pkg::CSR_Q_FACTOR;
      csr_wdata <= 18'(q);
      @(posedge clock);
      sb.q_reg = q;
      csr_index <= pec_pkg::CSR_SAMPLE_RATE;
      csr_wdata <= fs;
      @(posedge clock);
      sb.fs_reg = fs;
      csr_we <= 0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, clamping, Nyquist and zero frequency
      send_band(3'd0, 13'd0, 17'd1000);
      send_band(3'd7, 13'(3072), 17'd1000);
      send_band(3'd1, 13'(-3072), 17'd1000);
      send_band(3'd2, 13'h0FFF, 17'd5000);
      send_band(3'd3, 13'h1000, 17'd5000);
      send_band(3'd4, 13'h1FFF, 17'd22050);
      send_band(3'd5, 13'd256, 17'd22049);
      send_band(3'd6, 13'(-512), 17'd0);
      send_band(3'd0, 13'd3072, 17'd1);
      send_band(3'd1, 13'd768, 17'd11025);
      send_band(3'd2, 13'd768, 17'd11026);
      send_band(3'd3, 13'(-768), 17'd16000);
      send_band(3'd4, 13'd1, 17'd96000);
      send_band(3'd5, 13'd1024, 17'h1FFFF);
      send_band(3'd6, 13'h1555, 17'h0AAAA);
      send_band(3'd7, 13'h0AAA, 17'h15555);
      drain();

      // settings: defaults, extremes, beyond range, then random
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: write_settings(pec_pkg::Q_RESET, pec_pkg::FS_RESET);
            1: write_settings(pec_pkg::Q_MIN, pec_pkg::FS_MIN);
            2: write_settings(pec_pkg::Q_MAX, pec_pkg::FS_MAX);
            3: write_settings(12'd0, 18'h3FFFF);
            4: write_settings(12'hFFF, 18'd0);
            default: write_settings(12'($urandom_range(26, 2560)),
                                    18'($urandom_range(8000, 192000)));
         endcase
         no_idle = (ph == 2);
         repeat (105) send_random_band();
         drain();
      end
      no_idle = 0;

      if (sb.errors == 0 && sb.expected_q.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
